@@ design/pwdd_pkg.sv @@
// Package for the periodic work deadline dispatcher.
// Sizes, codes and the sequencer state type; no dependencies.
package pwdd_pkg;

  localparam int WORK_SLOTS  = 16;
  localparam int PRIO_LEVELS = 4;

  localparam int SLOT_W = (WORK_SLOTS > 1) ? $clog2(WORK_SLOTS) : 1;
  localparam int CNT_W  = $clog2(WORK_SLOTS + 1);
  localparam int CP_N   = 2 * PRIO_LEVELS;
  localparam int CP_W   = $clog2(CP_N);
  localparam int PR_W   = $clog2(PRIO_LEVELS + 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_ENABLED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIRES    = 1'b1;

  localparam logic [1:0] STAT_FIRED = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_REG   = 2'd2;
  localparam logic [1:0] STAT_REJ   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REG,
    ST_PRIO,
    ST_LOOP,
    ST_SCAN,
    ST_CHECK,
    ST_DIV_LOSS,
    ST_DIV_MEAN,
    ST_EMIT,
    ST_DONE
  } seq_state_e;

endpackage

@@ design/pwdd_div.sv @@
// Shared radix-2 restoring divider, 64-bit dividend by 32-bit divisor.
// One quotient bit per cycle; stand-alone, no package use.
module pwdd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic [31:0] rem_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] div_q;
  logic [32:0] sh;
  logic [32:0] sub;
  logic        ge;

  assign sh  = {rem_q, quo_q[63]};
  assign sub = sh - {1'b0, div_q};
  assign ge  = (sh >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], ge};
      rem_q <= ge ? sub[31:0] : sh[31:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ design/periodic_work_deadline_dispatcher_core.sv @@
// Top level of the periodic work deadline dispatcher: work table, sequencer.
// Uses pwdd_pkg and the shared divider pwdd_div.
//
//   channel | direction | handshake                 | word
//   in      | to core   | in_valid_i / in_ready_o   | cmd, slot, interval, class, prio, now
//   out     | from core | out_valid_o / out_ready_i | status, slot, count, mean loss, last
//   cfg     | to core   | cfg_valid_i / cfg_ready_o | register index, data
//
// An execute pass runs, per priority, one slot scan per fire attempt plus up to
// two runs of the shared divider per fire; the divider sets the pace. One word
// at a time.
// Reset clears the valid bits and per class-and-priority counts. A stalled out channel
// holds the sequencer at the next result.
module periodic_work_deadline_dispatcher_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [3:0]                     slot_i,
  input  logic [31:0]                    interval_i,
  input  logic                           time_class_i,
  input  logic [1:0]                     priority_req_i,
  input  logic [63:0]                    now_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [3:0]                     fired_slot_o,
  output logic [31:0]                    times_fired_o,
  output logic [63:0]                    mean_loss_o,
  output logic                           last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pwdd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  localparam int NS = pwdd_pkg::WORK_SLOTS;
  localparam int SW = pwdd_pkg::SLOT_W;

  // config
  logic       pass_en_q;
  logic [7:0] max_fires_q;

  // work table
  logic        valid_q [NS];
  logic        cls_tab [NS];
  logic [1:0]  prio_tab [NS];
  logic [31:0] ival_tab [NS];
  logic [63:0] due_tab [NS];
  logic [31:0] fc_tab [NS];
  logic [63:0] loss_tab [NS];
  logic [pwdd_pkg::CNT_W-1:0] cnt_q [pwdd_pkg::CP_N];
  logic [pwdd_pkg::CNT_W-1:0] cnt_d [pwdd_pkg::CP_N];

  // captured word
  logic        cls_q;
  logic [63:0] now_q;
  logic [31:0] ival_q;
  logic [1:0]  preq_q;
  logic [3:0]  slot_q;
  logic        rej_q;

  // sequencer
  pwdd_pkg::seq_state_e state_q, state_d;
  logic [SW-1:0]             rd_idx_q, rd_idx_d;
  logic [SW-1:0]             best_q, best_d;
  logic [63:0]               best_due_q, best_due_d;
  logic                      found_q, found_d;
  logic [pwdd_pkg::PR_W-1:0] prio_q, prio_d;
  logic [pwdd_pkg::CNT_W-1:0] size_q, size_d;
  logic [pwdd_pkg::CNT_W-1:0] done_q, done_d;
  logic [7:0]                exec_q, exec_d;

  // output register
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [3:0]  out_slot_q;
  logic [31:0] out_times_q;
  logic [63:0] out_mean_q;
  logic        out_last_q;

  logic        out_free;
  logic        in_acc;
  logic        load_out;
  logic [1:0]  ld_status;
  logic [3:0]  ld_slot;
  logic [31:0] ld_times;
  logic [63:0] ld_mean;
  logic        ld_last;

  // table-side signals
  logic        reg_we;
  logic        fire_we;
  logic        loss_we;
  logic [31:0] fc_new;
  logic [63:0] due_new;
  logic [64:0] due_sum;
  logic [63:0] diff;
  logic [63:0] lost;
  logic [64:0] loss_sum;
  logic [63:0] loss_new;
  logic        scan_match;
  logic [pwdd_pkg::CP_W-1:0] cp_sel;
  logic [pwdd_pkg::CP_W-1:0] cp_old;
  logic [pwdd_pkg::CP_W-1:0] cp_new;

  // divider
  logic        div_start;
  logic [63:0] div_a;
  logic [31:0] div_b;
  logic        div_done;
  logic [63:0] div_quo;
  logic [31:0] div_rem;

  pwdd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == pwdd_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign fired_slot_o  = out_slot_q;
  assign times_fired_o = out_times_q;
  assign mean_loss_o   = out_mean_q;
  assign last_o        = out_last_q;

  // datapath around the addressed slot
  assign fc_new   = (fc_tab[rd_idx_q] == 32'hFFFF_FFFF) ? fc_tab[rd_idx_q]
                                                        : fc_tab[rd_idx_q] + 32'd1;
  assign due_sum  = {1'b0, due_tab[rd_idx_q]} + {33'b0, ival_tab[rd_idx_q]};
  assign due_new  = due_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : due_sum[63:0];
  assign diff     = now_q - due_tab[rd_idx_q];
  assign lost     = diff - {32'b0, div_rem};
  assign loss_sum = {1'b0, loss_tab[rd_idx_q]} + {1'b0, lost};
  assign loss_new = loss_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : loss_sum[63:0];

  assign scan_match = valid_q[rd_idx_q] && (cls_tab[rd_idx_q] == cls_q) &&
                      (32'(prio_tab[rd_idx_q]) == 32'(prio_q));

  assign cp_sel = pwdd_pkg::CP_W'(32'(cls_q) * pwdd_pkg::PRIO_LEVELS + 32'(prio_q));
  assign cp_old = pwdd_pkg::CP_W'(32'(cls_tab[rd_idx_q]) * pwdd_pkg::PRIO_LEVELS
                                  + 32'(prio_tab[rd_idx_q]));
  assign cp_new = pwdd_pkg::CP_W'(32'(cls_q) * pwdd_pkg::PRIO_LEVELS + 32'(preq_q));

  always_comb begin
    for (int e = 0; e < pwdd_pkg::CP_N; e++) begin
      cnt_d[e] = cnt_q[e];
      if (reg_we && valid_q[rd_idx_q] && (32'(cp_old) == e) && (cnt_q[e] != '0)) begin
        cnt_d[e] = cnt_d[e] - 1'b1;
      end
      if (reg_we && (32'(cp_new) == e)) begin
        cnt_d[e] = cnt_d[e] + 1'b1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    best_d     = best_q;
    best_due_d = best_due_q;
    found_d    = found_q;
    prio_d     = prio_q;
    size_d     = size_q;
    done_d     = done_q;
    exec_d     = exec_q;
    load_out   = 1'b0;
    ld_status  = pwdd_pkg::STAT_DONE;
    ld_slot    = '0;
    ld_times   = '0;
    ld_mean    = '0;
    ld_last    = 1'b1;
    reg_we     = 1'b0;
    fire_we    = 1'b0;
    loss_we    = 1'b0;
    div_start  = 1'b0;
    div_a      = loss_tab[rd_idx_q];
    div_b      = fc_new;
    case (state_q)
      pwdd_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!cmd_i) begin
            rd_idx_d = SW'(slot_i);
            state_d  = pwdd_pkg::ST_REG;
          end else if (pass_en_q) begin
            prio_d  = '0;
            exec_d  = '0;
            state_d = pwdd_pkg::ST_PRIO;
          end else begin
            state_d = pwdd_pkg::ST_DONE;
          end
        end
      end
      pwdd_pkg::ST_REG: begin
        if (out_free) begin
          load_out  = 1'b1;
          ld_slot   = slot_q;
          ld_status = rej_q ? pwdd_pkg::STAT_REJ : pwdd_pkg::STAT_REG;
          reg_we    = !rej_q;
          state_d   = pwdd_pkg::ST_IDLE;
        end
      end
      pwdd_pkg::ST_PRIO: begin
        if (32'(prio_q) == pwdd_pkg::PRIO_LEVELS) begin
          state_d = pwdd_pkg::ST_DONE;
        end else begin
          size_d  = cnt_q[cp_sel];
          done_d  = '0;
          state_d = pwdd_pkg::ST_LOOP;
        end
      end
      pwdd_pkg::ST_LOOP: begin
        if (done_q >= size_q) begin
          prio_d  = prio_q + 1'b1;
          state_d = pwdd_pkg::ST_PRIO;
        end else begin
          rd_idx_d = '0;
          found_d  = 1'b0;
          state_d  = pwdd_pkg::ST_SCAN;
        end
      end
      pwdd_pkg::ST_SCAN: begin
        if (scan_match && (!found_q || (due_tab[rd_idx_q] < best_due_q))) begin
          found_d    = 1'b1;
          best_d     = rd_idx_q;
          best_due_d = due_tab[rd_idx_q];
        end
        if (32'(rd_idx_q) == NS - 1) begin
          rd_idx_d = best_d;
          state_d  = pwdd_pkg::ST_CHECK;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      pwdd_pkg::ST_CHECK: begin
        if (!found_q || (now_q < best_due_q)) begin
          prio_d  = prio_q + 1'b1;
          state_d = pwdd_pkg::ST_PRIO;
        end else begin
          fire_we   = 1'b1;
          div_start = 1'b1;
          if (now_q > due_new) begin
            div_a   = now_q - due_new;
            div_b   = ival_tab[rd_idx_q];
            state_d = pwdd_pkg::ST_DIV_LOSS;
          end else begin
            state_d = pwdd_pkg::ST_DIV_MEAN;
          end
        end
      end
      pwdd_pkg::ST_DIV_LOSS: begin
        if (div_done) begin
          // due already advanced, so diff is now minus the new due
          loss_we   = 1'b1;
          div_start = 1'b1;
          div_a     = loss_new;
          div_b     = fc_tab[rd_idx_q];
          state_d   = pwdd_pkg::ST_DIV_MEAN;
        end
      end
      pwdd_pkg::ST_DIV_MEAN: begin
        if (div_done) begin
          state_d = pwdd_pkg::ST_EMIT;
        end
      end
      pwdd_pkg::ST_EMIT: begin
        if (out_free) begin
          load_out  = 1'b1;
          ld_status = pwdd_pkg::STAT_FIRED;
          ld_slot   = 4'(rd_idx_q);
          ld_times  = fc_tab[rd_idx_q];
          ld_mean   = div_quo;
          ld_last   = 1'b0;
          done_d    = done_q + 1'b1;
          exec_d    = exec_q + 8'd1;
          if (exec_d >= max_fires_q) begin
            prio_d  = prio_q + 1'b1;
            state_d = pwdd_pkg::ST_PRIO;
          end else begin
            state_d = pwdd_pkg::ST_LOOP;
          end
        end
      end
      pwdd_pkg::ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = pwdd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pwdd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pwdd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      pass_en_q   <= 1'b0;
      max_fires_q <= 8'd255;
      for (int e = 0; e < pwdd_pkg::CP_N; e++) begin
        cnt_q[e] <= '0;
      end
      for (int s = 0; s < NS; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pwdd_pkg::CFG_PASS_ENABLED: pass_en_q   <= cfg_data_i[0];
          pwdd_pkg::CFG_MAX_FIRES:    max_fires_q <= cfg_data_i;
          default: ;
        endcase
      end
      cnt_q <= cnt_d;
      if (reg_we) begin
        valid_q[rd_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    best_q     <= best_d;
    best_due_q <= best_due_d;
    found_q    <= found_d;
    prio_q     <= prio_d;
    size_q     <= size_d;
    done_q     <= done_d;
    exec_q     <= exec_d;
    if (in_acc) begin
      cls_q  <= time_class_i;
      now_q  <= now_value_i;
      ival_q <= interval_i;
      preq_q <= priority_req_i;
      slot_q <= slot_i;
      rej_q  <= (interval_i == 32'd0) || (32'(slot_i) >= NS) ||
                (32'(priority_req_i) >= pwdd_pkg::PRIO_LEVELS);
    end
    if (load_out) begin
      out_status_q <= ld_status;
      out_slot_q   <= ld_slot;
      out_times_q  <= ld_times;
      out_mean_q   <= ld_mean;
      out_last_q   <= ld_last;
    end
    if (reg_we) begin
      cls_tab[rd_idx_q]  <= cls_q;
      prio_tab[rd_idx_q] <= preq_q;
      ival_tab[rd_idx_q] <= ival_q;
      due_tab[rd_idx_q]  <= '0;
      fc_tab[rd_idx_q]   <= '0;
      loss_tab[rd_idx_q] <= '0;
    end
    if (fire_we) begin
      fc_tab[rd_idx_q]  <= fc_new;
      due_tab[rd_idx_q] <= due_new;
    end
    if (loss_we) begin
      loss_tab[rd_idx_q] <= loss_new;
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench for periodic_work_deadline_dispatcher_core: directed and random words,
// scoreboard with its own dispatcher table. Depends on pwdd_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [31:0] fires;
    logic [63:0] mloss;
    logic        last;
  } result_t;

  class dispatch_board;
    bit          enabled;
    bit [7:0]    fire_limit;
    bit          valid [16];
    bit          cls [16];
    bit [1:0]    prio [16];
    bit [31:0]   ival [16];
    bit [63:0]   due [16];
    bit [31:0]   count [16];
    bit [63:0]   loss [16];
    int unsigned group [8];
    result_t     pending [$];
    int          errors;

    function void clear();
      enabled = 0;
      fire_limit = 8'd255;
      errors = 0;
      pending.delete();
      foreach (valid[s]) valid[s] = 0;
      foreach (group[g]) group[g] = 0;
    endfunction

    function void push(logic [1:0] st, logic [3:0] sl, logic [31:0] f,
                       logic [63:0] m, logic l);
      result_t r;
      r.status = st; r.slot = sl; r.fires = f; r.mloss = m; r.last = l;
      pending.push_back(r);
    endfunction

    function int earliest(bit c, bit [1:0] p);
      int best;
      best = -1;
      for (int s = 0; s < 16; s++)
        if (valid[s] && cls[s] == c && prio[s] == p)
          if (best < 0 || due[s] < due[best]) best = s;
      return best;
    endfunction

    // note an accepted input word and queue its results
    function void note_input(bit cmd, bit [3:0] sl, bit [31:0] iv, bit c,
                             bit [1:0] p, bit [63:0] now);
      int unsigned executed, done, size;
      int w;
      bit [63:0] nd, lost;
      bit stop;
      if (!cmd) begin
        if (iv == 0) begin
          push(pwdd_pkg::STAT_REJ, sl, 0, 0, 1);
          return;
        end
        if (valid[sl] && group[cls[sl]*4 + prio[sl]] > 0) group[cls[sl]*4 + prio[sl]]--;
        valid[sl] = 1; cls[sl] = c; prio[sl] = p; ival[sl] = iv;
        due[sl] = 0; count[sl] = 0; loss[sl] = 0;
        group[c*4 + p]++;
        push(pwdd_pkg::STAT_REG, sl, 0, 0, 1);
        return;
      end
      if (enabled) begin
        executed = 0;
        for (int q = 0; q < 4; q++) begin
          size = group[c*4 + q];
          done = 0;
          stop = 0;
          while (done < size && !stop) begin
            w = earliest(c, q[1:0]);
            if (w < 0 || now < due[w]) begin
              stop = 1;
            end else begin
              if (count[w] != 32'hFFFF_FFFF) count[w]++;
              nd = due[w];
              nd = (nd > 64'hFFFF_FFFF_FFFF_FFFF - ival[w]) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                           : nd + ival[w];
              due[w] = nd;
              if (now > nd) begin
                lost = ((now - nd) / ival[w]) * ival[w];
                loss[w] = (loss[w] > 64'hFFFF_FFFF_FFFF_FFFF - lost)
                          ? 64'hFFFF_FFFF_FFFF_FFFF : loss[w] + lost;
              end
              push(pwdd_pkg::STAT_FIRED, w[3:0], count[w], loss[w] / count[w], 0);
              done++;
              executed++;
              if (executed >= fire_limit) stop = 1;
            end
          end
        end
      end
      push(pwdd_pkg::STAT_DONE, 0, 0, 0, 1);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word status=%0d slot=%0d", $time, got.status, got.slot);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status != exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status); errors++;
      end
      if (got.slot != exp.slot) begin
        $display("%0t: slot exp %0d got %0d", $time, exp.slot, got.slot); errors++;
      end
      if (got.fires != exp.fires) begin
        $display("%0t: times_fired exp %0d got %0d", $time, exp.fires, got.fires); errors++;
      end
      if (got.mloss != exp.mloss) begin
        $display("%0t: mean_loss exp %0d got %0d", $time, exp.mloss, got.mloss); errors++;
      end
      if (got.last != exp.last) begin
        $display("%0t: last exp %0d got %0d", $time, exp.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_ready_o;
  logic cmd_i = 0;
  logic [3:0] slot_i = 0;
  logic [31:0] interval_i = 0;
  logic time_class_i = 0;
  logic [1:0] priority_req_i = 0;
  logic [63:0] now_value_i = 0;
  logic out_valid_o, out_ready_i = 0;
  logic [1:0] status_o;
  logic [3:0] fired_slot_o;
  logic [31:0] times_fired_o;
  logic [63:0] mean_loss_o;
  logic last_o;
  logic cfg_valid_i = 0, cfg_ready_o;
  logic [pwdd_pkg::CFG_IDX_W-1:0] cfg_index_i = pwdd_pkg::CFG_PASS_ENABLED;
  logic [7:0] cfg_data_i = 0;

  dispatch_board board;
  bit in_done;
  int unsigned quiet;
  localparam int unsigned QUIET_LIMIT = 200000;
  bit [63:0] clock_now [2];

  always #5 clk_i = ~clk_i;

  periodic_work_deadline_dispatcher_core dut (.*);

  // sample at rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        board.note_input(cmd_i, slot_i, interval_i, time_class_i, priority_req_i,
                         now_value_i);
      if (out_valid_o && out_ready_i)
        board.check_result({status_o, fired_slot_o, times_fired_o, mean_loss_o, last_o});
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet <= 0;
      else
        quiet <= quiet + 1;
    end
  end

  // receiver with random stalls, runs of no stalling
  initial begin
    int unsigned gap;
    forever begin
      @(negedge clk_i);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        out_ready_i <= 0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // valid stays high after acceptance until the next negedge decision
  task automatic send_word(bit cmd, bit [3:0] sl, bit [31:0] iv, bit c, bit [1:0] p,
                           bit [63:0] now);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1; cmd_i <= cmd; slot_i <= sl; interval_i <= iv;
    time_class_i <= c; priority_req_i <= p; now_value_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [pwdd_pkg::CFG_IDX_W-1:0] idx, bit [7:0] data);
    release_input();
    drain();
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == pwdd_pkg::CFG_PASS_ENABLED) board.enabled = data[0];
    else board.fire_limit = data;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic random_word();
    bit c;
    bit [31:0] iv;
    c = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 3))
        0: iv = 0;
        1: iv = $urandom;
        default: iv = $urandom_range(1, 40);
      endcase
      send_word(1'b0, 4'($urandom_range(0, 15)), iv, c, 2'($urandom_range(0, 3)),
                {$urandom, $urandom});
    end else begin
      clock_now[c] += 64'($urandom_range(0, 120));
      if ($urandom_range(0, 15) == 0) clock_now[c] = {$urandom, $urandom};
      send_word(1'b1, 4'($urandom_range(0, 15)), $urandom, c, 2'($urandom_range(0, 3)),
                clock_now[c]);
    end
  endtask

  initial begin
    board = new();
    board.clear();
    quiet = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed: pass while disabled, rejects, field extremes
    send_word(1, 4'hF, 32'hFFFF_FFFF, 1, 3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(0, 4'd3, 0, 0, 0, 0);
    send_word(0, 4'd0, 32'd10, 0, 0, 0);
    send_word(0, 4'd15, 32'hFFFF_FFFF, 1, 3, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(0, 4'd5, 32'd7, 0, 2, 0);
    send_word(0, 4'd6, 32'd7, 0, 2, 0);
    send_word(1, 0, 0, 0, 0, 64'd100);
    write_reg(pwdd_pkg::CFG_PASS_ENABLED, 8'd1);
    send_word(1, 0, 0, 0, 0, 64'd100);
    send_word(1, 0, 0, 0, 0, 64'd105);
    send_word(1, 0, 0, 1, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(1, 0, 0, 1, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(0, 4'd5, 32'd3, 1, 1, 0);   // re-register moves class and priority
    send_word(1, 0, 0, 1, 0, 64'd50);
    write_reg(pwdd_pkg::CFG_MAX_FIRES, 8'd1);
    send_word(1, 0, 0, 0, 0, 64'd1000);
    write_reg(pwdd_pkg::CFG_MAX_FIRES, 8'd0);       // each priority stops after its first fire
    send_word(1, 0, 0, 0, 0, 64'd2000);
    write_reg(pwdd_pkg::CFG_MAX_FIRES, 8'd255);
    clock_now[0] = 3000; clock_now[1] = 3000;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) write_reg(pwdd_pkg::CFG_MAX_FIRES, 8'd2);
      if (ph == 2) write_reg(pwdd_pkg::CFG_PASS_ENABLED, 8'd0);
      if (ph == 3) begin
        write_reg(pwdd_pkg::CFG_PASS_ENABLED, 8'd1);
        write_reg(pwdd_pkg::CFG_MAX_FIRES, 8'($urandom_range(3, 255)));
      end
      repeat (28) random_word();
    end
    release_input();
    in_done = 1;
  end

  initial begin
    wait (in_done);
    while (board.pending.size() != 0 && quiet < QUIET_LIMIT) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (board.pending.size() != 0 || quiet >= QUIET_LIMIT) board.errors++;
    if (board.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    wait (quiet >= QUIET_LIMIT && !in_done);
    $display("Test completed with failures");
    $finish;
  end
endmodule
